// ===== design/bchm_pkg.sv =====
// Shared types and constants for the button change heat map.
`timescale 1ns / 1ps

package bchm_pkg;

  localparam int MAX_FRAMES_DEF = 4096;
  localparam int MAX_PADS_DEF   = 4;
  localparam int BUTTONS        = 8;
  localparam int ROW_W          = 4 * BUTTONS;
  localparam int FRAME_W        = 12;

  typedef enum logic [1:0] {
    OP_MARK = 2'd0,
    OP_FADE = 2'd1,
    OP_FILL = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [FRAME_W-1:0] frame;
    logic [1:0]         pad;
    logic [7:0]         mine;
    logic [7:0]         theirs;
    logic [4:0]         button;
  } in_word_t;

  typedef struct packed {
    logic [3:0] heat;
    logic [7:0] diff_bits;
  } out_word_t;

  typedef struct packed {
    logic        map_enable;
    logic [1:0]  pad_mode;
    logic [12:0] frame_count;
  } cfg_t;

endpackage

// ===== design/bchm_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module bchm_regs
  import bchm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_PADS   = 2'd1;
  localparam logic [1:0] REG_FRAMES = 2'd2;

  cfg_t cfg_r;
  logic wr_acc;

  assign cfg_pready = 1'b1;
  assign wr_acc     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_acc) begin
      case (cfg_paddr[3:2])
        REG_ENABLE: cfg_r.map_enable  <= cfg_pwdata[0];
        REG_PADS:   cfg_r.pad_mode    <= cfg_pwdata[1:0];
        REG_FRAMES: cfg_r.frame_count <= cfg_pwdata[12:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_ENABLE: cfg_prdata = {31'd0, cfg_r.map_enable};
      REG_PADS:   cfg_prdata = {30'd0, cfg_r.pad_mode};
      REG_FRAMES: cfg_prdata = {19'd0, cfg_r.frame_count};
      default:    cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/bchm_ram.sv =====
// Heat row memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module bchm_ram
  import bchm_pkg::*;
#(
  parameter int DEPTH = MAX_FRAMES_DEF * MAX_PADS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/bchm_seq.sv =====
// Operation sequencer: clearing pass, row read-modify-write, fill and fade sweeps, result register.
`timescale 1ns / 1ps

module bchm_seq
  import bchm_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int MAX_PADS   = MAX_PADS_DEF,
  parameter int ROWS       = MAX_FRAMES * MAX_PADS,
  parameter int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  output logic              rd_en,
  output logic [ROW_AW-1:0] rd_addr,
  input  logic [ROW_W-1:0]  rd_data,
  output logic              wr_en,
  output logic [ROW_AW-1:0] wr_addr,
  output logic [ROW_W-1:0]  wr_data
);

  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_FILL,
    S_FADE,
    S_HOLD
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic              hit_r, hit_nxt;
  logic [7:0]        diff_r, diff_nxt;
  logic [2:0]        nib_r, nib_nxt;
  logic [2:0]        pads_r, pads_nxt;
  logic [1:0]        fill_cnt_r, fill_cnt_nxt;
  logic [ROW_AW-1:0] cnt_r, cnt_nxt;
  logic [ROW_AW-1:0] wr_addr_r, wr_addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              issued_r, issued_nxt;
  out_word_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              can_push;
  logic              fin;
  out_word_t         res;
  logic [2:0]        pads;
  logic              frame_ok;
  logic [1:0]        rd_pad;

  function automatic logic [ROW_AW-1:0] row_addr(input logic [FRAME_W-1:0] f,
                                                 input logic [1:0] p);
    logic [31:0] full;
    full = 32'(f) * 32'(MAX_PADS) + 32'(p);
    return full[ROW_AW-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] nibble_mask(input logic [BUTTONS-1:0] bits);
    logic [ROW_W-1:0] m;
    m = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      if (bits[i]) m[4*i +: 4] = 4'hF;
    end
    return m;
  endfunction

  // Every nonzero nibble drops by one: OR-fold each nibble into its low bit.
  function automatic logic [ROW_W-1:0] fade_row(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] t;
    logic [ROW_W-1:0] ones;
    t = v | (v >> 1);
    t = t | (t >> 2);
    ones = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      ones[4*i] = 1'b1;
    end
    return v - (t & ones);
  endfunction

  always_comb begin
    logic [2:0] p;
    case (cfg.pad_mode)
      2'd0:    p = 3'd1;
      2'd1:    p = 3'd2;
      default: p = 3'd4;
    endcase
    pads = (32'(p) > 32'(MAX_PADS)) ? 3'(MAX_PADS) : p;
  end

  assign frame_ok = ({1'b0, in_word.frame} < cfg.frame_count) &&
                    (32'(in_word.frame) < 32'(MAX_FRAMES));
  assign rd_pad   = (in_word.operation == OP_READ) ? in_word.button[4:3] : in_word.pad;
  assign can_push = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    hit_nxt      = hit_r;
    diff_nxt     = diff_r;
    nib_nxt      = nib_r;
    pads_nxt     = pads_r;
    fill_cnt_nxt = fill_cnt_r;
    cnt_nxt      = cnt_r;
    wr_addr_nxt  = wr_addr_r;
    rd_vld_nxt   = rd_vld_r;
    issued_nxt   = issued_r;
    res_nxt      = res_r;
    out_word_nxt = out_word_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    rd_en   = 1'b0;
    rd_addr = row_addr(in_word.frame, rd_pad);
    wr_en   = 1'b0;
    wr_addr = wr_addr_r;
    wr_data = '0;
    fin     = 1'b0;
    res     = '0;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        if (cnt_r == ROW_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          rd_en  = (in_word.operation == OP_MARK) || (in_word.operation == OP_READ);
          op_nxt = in_word.operation;
          case (in_word.operation)
            OP_MARK: begin
              diff_nxt    = in_word.mine ^ in_word.theirs;
              hit_nxt     = cfg.map_enable && frame_ok && ({1'b0, in_word.pad} < pads);
              wr_addr_nxt = row_addr(in_word.frame, in_word.pad);
              state_nxt   = S_RMW;
            end
            OP_READ: begin
              hit_nxt   = cfg.map_enable && frame_ok &&
                          ({1'b0, in_word.button[4:3]} < pads);
              nib_nxt   = in_word.button[2:0];
              state_nxt = S_RMW;
            end
            OP_FILL: begin
              hit_nxt      = frame_ok;
              pads_nxt     = pads;
              fill_cnt_nxt = 2'd0;
              wr_addr_nxt  = row_addr(in_word.frame, 2'd0);
              state_nxt    = S_FILL;
            end
            OP_FADE: begin
              cnt_nxt    = '0;
              issued_nxt = 1'b0;
              rd_vld_nxt = 1'b0;
              state_nxt  = S_FADE;
            end
            default: ;
          endcase
        end
      end

      S_RMW: begin
        fin = 1'b1;
        if (op_r == OP_MARK) begin
          wr_en         = hit_r;
          wr_data       = rd_data | nibble_mask(diff_r);
          res.diff_bits = diff_r;
        end else if (hit_r) begin
          res.heat = rd_data[{nib_r, 2'b00} +: 4];
        end
      end

      S_FILL: begin
        wr_en        = hit_r;
        wr_data      = '1;
        wr_addr_nxt  = wr_addr_r + 1'b1;
        fill_cnt_nxt = fill_cnt_r + 1'b1;
        fin          = ({1'b0, fill_cnt_r} == pads_r - 3'd1);
      end

      S_FADE: begin
        // Read row n while row n-1 is written back; the two never collide.
        rd_en   = !issued_r;
        rd_addr = cnt_r;
        wr_en   = rd_vld_r;
        wr_data = fade_row(rd_data);
        rd_vld_nxt = !issued_r;
        if (!issued_r) begin
          wr_addr_nxt = cnt_r;
          if (cnt_r == ROW_LAST) begin
            issued_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        fin = issued_r && rd_vld_r;
      end

      S_HOLD: begin
        if (can_push) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      if (can_push) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = res;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = res;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      issued_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      issued_r    <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    hit_r      <= hit_nxt;
    diff_r     <= diff_nxt;
    nib_r      <= nib_nxt;
    pads_r     <= pads_nxt;
    fill_cnt_r <= fill_cnt_nxt;
    wr_addr_r  <= wr_addr_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// ===== design/button_change_heat_map_unit.sv =====
// Top level of the button change heat map: registers, sequencer and heat row memory.
//
//  port group   dir   handshake            word
//  in_          in    in_valid / in_stall    in_word_t  (operation, frame, pad, mine, theirs, button)
//  out_         out   out_valid / out_stall  out_word_t (heat, diff_bits)
//  cfg_         in    APB write / read       map_enable, pad_mode, frame_count
//
// Mark and read do one memory read, then mark writes the row back and both return a result.
// Fill writes pads-in-use rows, one row write per cycle.
// Fade sweeps every row through the single read and write port.
// After reset a clearing pass writes zero to all ROWS rows (16384 by default);
// in_stall stays high until it ends, configuration writes are taken meanwhile.
// A finished result waits in the output register; the next word is accepted meanwhile
// and only holds at its own end if the output is still stalled.
`timescale 1ns / 1ps

module button_change_heat_map_unit
  import bchm_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int MAX_PADS   = MAX_PADS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ROWS   = MAX_FRAMES * MAX_PADS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  cfg_t              cfg;
  logic              rd_en;
  logic [ROW_AW-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_data;
  logic              wr_en;
  logic [ROW_AW-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;

  bchm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bchm_seq #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_PADS   (MAX_PADS),
    .ROWS       (ROWS),
    .ROW_AW     (ROW_AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  bchm_ram #(
    .DEPTH (ROWS),
    .AW    (ROW_AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ===== bench/button_change_heat_map_unit_test.sv =====
// Self-checking testbench for the button change heat map unit.
`timescale 1ns / 1ps

module button_change_heat_map_unit_test;
  import bchm_pkg::*;

  localparam int ROWS        = MAX_FRAMES_DEF * MAX_PADS_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MAX_SHOWN   = 10;

  typedef enum int {
    REG_MAP_ENABLE  = 0,
    REG_PAD_MODE    = 1,
    REG_FRAME_COUNT = 2
  } reg_idx_t;

  // Shadow of the heat table plus the queue of words the block still owes us.
  class heat_map_scoreboard;
    bit [31:0] heat_table [ROWS];
    bit        map_enable;
    bit [1:0]  pad_mode;
    bit [12:0] frame_count;
    out_word_t due_results [$];
    int        mismatches;

    function int unsigned pads_in_use();
      case (pad_mode)
        2'd0: return 1;
        2'd1: return 2;
        default: return 4;
      endcase
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_MAP_ENABLE: map_enable = value[0];
        REG_PAD_MODE: pad_mode = value[1:0];
        default: frame_count = value[12:0];
      endcase
    endfunction

    function void apply_word(in_word_t w);
      out_word_t   r;
      int unsigned row;
      bit [31:0]   v;
      bit          in_log;
      r = '0;
      row = int'(w.frame) * MAX_PADS_DEF;
      in_log = int'(w.frame) < int'(frame_count);
      case (w.operation)
        OP_MARK: begin
          r.diff_bits = w.mine ^ w.theirs;
          if (map_enable && in_log && w.pad < pads_in_use()) begin
            for (int b = 0; b < BUTTONS; b++)
              if (r.diff_bits[b]) heat_table[row + w.pad][4*b +: 4] = 4'hF;
          end
        end
        OP_FADE: begin
          // whole table, independent of enable and frame count
          for (int i = 0; i < ROWS; i++) begin
            v = heat_table[i];
            for (int b = 0; b < BUTTONS; b++)
              if (v[4*b +: 4] != 4'd0) v[4*b +: 4] = v[4*b +: 4] - 4'd1;
            heat_table[i] = v;
          end
        end
        OP_FILL: begin
          if (in_log) begin
            for (int p = 0; p < pads_in_use(); p++) heat_table[row + p] = '1;
          end
        end
        default: begin
          if (map_enable && in_log && w.button < BUTTONS * pads_in_use())
            r.heat = heat_table[row + w.button[4:3]][4*w.button[2:0] +: 4];
        end
      endcase
      due_results.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected word: heat %0d diff_bits %02h", got.heat, got.diff_bits);
        return;
      end
      want = due_results.pop_front();
      if (got.heat !== want.heat || got.diff_bits !== want.diff_bits) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("mismatch: heat exp %0d got %0d, diff_bits exp %02h got %02h",
                   want.heat, got.heat, want.diff_bits, got.diff_bits);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  heat_map_scoreboard sb;
  int          gap_pct;
  int          stall_pct;
  int          fades_left;
  int unsigned cycles;

  button_change_heat_map_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: check accepted words, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // the task idles after the access to keep back-to-back writes apart
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 4'(4 * idx);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic send_word(in_word_t w);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sb.apply_word(w);
  endtask

  // block is idle once every owed word is back
  task automatic drain();
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_word_t make_word(op_t op, int frame, int pad, int mine, int theirs,
                                         int button);
    in_word_t w;
    w.operation = op;
    w.frame     = FRAME_W'(frame);
    w.pad       = 2'(pad);
    w.mine      = 8'(mine);
    w.theirs    = 8'(theirs);
    w.button    = 5'(button);
    return w;
  endfunction

  // frames cluster around the frame count edge so marks, fills and reads share rows
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pads;
    int unsigned base;
    int unsigned pick;
    pads = sb.pads_in_use();
    base = (sb.frame_count > 4) ? sb.frame_count - 4 : 0;
    pick = $urandom_range(0, 99);
    w = in_word_t'($urandom);
    if (pick < 2 && fades_left > 0) begin
      w.operation = OP_FADE;
      fades_left--;
    end else if (pick < 12) begin
      w.operation = OP_FILL;
    end else if (pick < 52) begin
      w.operation = OP_MARK;
    end else begin
      w.operation = OP_READ;
    end
    if ($urandom_range(0, 7) != 0) w.frame = FRAME_W'(base + $urandom_range(0, 7));
    if ($urandom_range(0, 3) != 0) w.pad = 2'($urandom_range(0, pads - 1));
    if ($urandom_range(0, 3) != 0) w.button = 5'($urandom_range(0, 8 * pads - 1));
    if ($urandom_range(0, 7) == 0) w.theirs = w.mine;
    return w;
  endfunction

  task automatic run_phase(bit en, bit [1:0] mode, bit [12:0] fc, int gap, int stall,
                           int count);
    drain();
    write_reg(REG_MAP_ENABLE, 32'(en));
    write_reg(REG_PAD_MODE, 32'(mode));
    write_reg(REG_FRAME_COUNT, 32'(fc));
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) send_word(random_word());
    in_valid <= 1'b0;
  endtask

  initial begin
    sb          = new();
    gap_pct     = 0;
    stall_pct   = 0;
    fades_left  = 14;
    cycles      = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_word     <= '0;
    out_stall   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full table, four pads, corners of every field
    write_reg(REG_MAP_ENABLE, 32'd1);
    write_reg(REG_PAD_MODE, 32'd2);
    write_reg(REG_FRAME_COUNT, 32'd4096);
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0));
    send_word(make_word(OP_MARK, 0, 0, 8'hFF, 8'h00, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 7));
    send_word(make_word(OP_MARK, 4095, 3, 8'hAA, 8'h55, 31));
    send_word(make_word(OP_READ, 4095, 0, 0, 0, 31));
    send_word(make_word(OP_MARK, 4095, 3, 8'h5A, 8'h5A, 0));
    send_word(make_word(OP_MARK, 2, 0, 8'h00, 8'hFF, 0));
    send_word(make_word(OP_FILL, 4095, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 4095, 0, 0, 0, 8));
    send_word(make_word(OP_FADE, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 4095, 0, 0, 0, 31));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0));
    send_word(make_word(OP_MARK, 1, 2, 8'h81, 8'h00, 0));
    send_word(make_word(OP_READ, 1, 0, 0, 0, 16));
    send_word(make_word(OP_READ, 1, 0, 0, 0, 17));
    send_word(make_word(OP_READ, 1, 0, 0, 0, 23));
    send_word(make_word(OP_FADE, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 1, 0, 0, 0, 23));
    send_word(make_word(OP_READ, 0, 3, 8'hFF, 8'hFF, 5));
    send_word(make_word(OP_READ, 2, 0, 0, 0, 3));
    in_valid <= 1'b0;

    run_phase(1'b1, 2'd0, 13'd1,    0,  0,  75);
    run_phase(1'b1, 2'd1, 13'd100,  54, 0,  75);
    run_phase(1'b0, 2'd2, 13'd4096, 0,  54, 75);
    run_phase(1'b1, 2'd3, 13'd4095, 38, 38, 75);
    run_phase(1'b1, 2'd2, 13'd0,    0,  0,  75);
    run_phase(1'b1, 2'd2, 13'd2048, 54, 0,  75);
    run_phase(1'b1, 2'd1, 13'd4096, 0,  54, 75);
    run_phase(1'b1, 2'd0, 13'd7,    38, 38, 75);

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
